// ===== hdl/tilt_posture_alarm_unit_defines.svh =====
// assertion macros for the tilt posture alarm checker
// no dependencies; taken in by the checker with an include
`ifndef TILT_POSTURE_ALARM_UNIT_DEFINES_SVH
`define TILT_POSTURE_ALARM_UNIT_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define TPA_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define TPA_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/tpa_pkg.sv =====
// shared widths, register indexes, reset values and result codes
// for the tilt posture alarm unit and its checker; no dependencies
package tpa_pkg;

    localparam int CFG_ADDR_W = 4;
    localparam int CFG_DATA_W = 32;
    localparam int SAMPLE_W   = 16;
    localparam int TIME_W     = 63;
    localparam int S_DATA_W   = 112;
    localparam int M_DATA_W   = 8;
    localparam int DIGIT_W    = 4;

    localparam logic [CFG_ADDR_W-1:0] REG_WARN_RATIO = 4'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_BAD_RATIO  = 4'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_COOLDOWN   = 4'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_STUDY_MODE = 4'd3;

    localparam logic [CFG_DATA_W-1:0] WARN_RATIO_RST = 32'd4705;
    localparam logic [CFG_DATA_W-1:0] BAD_RATIO_RST  = 32'd21845;
    localparam logic [CFG_DATA_W-1:0] COOLDOWN_RST   = 32'd20000000;

    typedef logic [1:0] verdict_t;
    typedef logic [1:0] face_t;

    localparam verdict_t VERDICT_GOOD   = 2'd0;
    localparam verdict_t VERDICT_SLIGHT = 2'd1;
    localparam verdict_t VERDICT_BAD    = 2'd2;
    localparam verdict_t VERDICT_NONE   = 2'd3;

    localparam face_t FACE_KEEP  = 2'd0;
    localparam face_t FACE_ANGRY = 2'd1;
    localparam face_t FACE_HAPPY = 2'd2;

endpackage

// ===== hdl/tilt_posture_alarm_unit.sv =====
// tilt posture alarm: one accelerometer word in, one verdict word out
// depends on tpa_pkg
//
// s_ channel word: read_ok, accel_x, accel_y, accel_z, time_us (lowest bit up).
// m_ channel word: verdict, face_request, send_alert, wake_sensor, zero pad.
// cfg port: cfg_we writes cfg_wdata into register cfg_addr at the clock edge;
// 0 warn ratio, 1 bad ratio, 2 cooldown, 3 study mode, other indexes ignored.
// a word is taken only while the sequencer is idle. a good reading runs
// radix-16 squaring (ST_SQR), forms y*y + z*z (ST_SIDE), runs radix-16
// ratio products (ST_MUL) and ends in the decision state (ST_DEC); the next
// word is taken only once the sequencer is back in idle, so a word is never
// taken before the last one is through. a failed read skips the arithmetic
// and goes straight from idle to the decision state.
// the result sits in an output register; while the receiver stalls a new word
// is still taken and computed, and its decision waits until the register frees.
// aresetn (synchronous, low) restores the default ratios, cooldown and study
// mode off, forgets alert history and bad state and empties the output.
module tilt_posture_alarm_unit (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // read_ok, accel_x, accel_y, accel_z, time_us
    input  logic [tpa_pkg::S_DATA_W-1:0]         s_tdata,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // verdict, face_request, send_alert, wake_sensor, zero pad
    output logic [tpa_pkg::M_DATA_W-1:0]         m_tdata,
    input  logic                                 cfg_we,
    input  logic [tpa_pkg::CFG_ADDR_W-1:0]       cfg_addr,
    input  logic [tpa_pkg::CFG_DATA_W-1:0]       cfg_wdata
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SQR  = 3'd1;
    localparam logic [2:0] ST_SIDE = 3'd2;
    localparam logic [2:0] ST_MUL  = 3'd3;
    localparam logic [2:0] ST_DEC  = 3'd4;

    localparam logic [2:0] SQR_LAST = 3'd3;
    localparam logic [2:0] MUL_LAST = 3'd7;

    // control state
    logic [2:0]                        state_reg, state_next;
    logic [2:0]                        cnt_reg, cnt_next;
    logic                              m_tvalid_reg, m_tvalid_next;
    logic [tpa_pkg::TIME_W-1:0]        last_alert_reg, last_alert_next;
    logic                              sent_before_reg, sent_before_next;
    logic                              was_bad_reg, was_bad_next;
    logic [tpa_pkg::CFG_DATA_W-1:0]    warn_ratio_reg, warn_ratio_next;
    logic [tpa_pkg::CFG_DATA_W-1:0]    bad_ratio_reg, bad_ratio_next;
    logic [tpa_pkg::CFG_DATA_W-1:0]    cooldown_reg, cooldown_next;
    logic                              study_reg, study_next;

    // datapath
    logic                              ok_reg, ok_next;
    logic [tpa_pkg::SAMPLE_W-1:0]      xm_reg, xm_next, ym_reg, ym_next, zm_reg, zm_next;
    logic [tpa_pkg::SAMPLE_W-1:0]      xd_reg, xd_next, yd_reg, yd_next, zd_reg, zd_next;
    logic [31:0]                       xsq_reg, xsq_next, ysq_reg, ysq_next;
    logic [31:0]                       zsq_reg, zsq_next;
    logic [31:0]                       sd_reg, sd_next;
    logic [63:0]                       pw_reg, pw_next, pb_reg, pb_next;
    logic [tpa_pkg::TIME_W-1:0]        time_reg, time_next;
    tpa_pkg::verdict_t                 verdict_reg, verdict_next;
    tpa_pkg::face_t                    face_reg, face_next;
    logic                              alert_reg, alert_next;
    logic                              wake_reg, wake_next;

    logic                              in_ok;
    logic [tpa_pkg::SAMPLE_W-1:0]      in_x, in_y, in_z;
    logic [19:0]                       xp, yp, zp;
    logic [35:0]                       wp, bp;
    logic [63:0]                       xsq_ext;
    logic                              is_bad, is_warn, elapsed, out_free;
    logic [tpa_pkg::TIME_W-1:0]        since;

    assign in_ok = s_tdata[0];
    assign in_x  = s_tdata[16:1];
    assign in_y  = s_tdata[32:17];
    assign in_z  = s_tdata[48:33];

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {2'b00, wake_reg, alert_reg, face_reg, verdict_reg};
    assign out_free = !m_tvalid_reg || m_tready;

    // one digit products
    assign xp = 20'(xm_reg) * 20'(xd_reg[15:12]);
    assign yp = 20'(ym_reg) * 20'(yd_reg[15:12]);
    assign zp = 20'(zm_reg) * 20'(zd_reg[15:12]);
    assign wp = 36'(warn_ratio_reg) * 36'(sd_reg[31:28]);
    assign bp = 36'(bad_ratio_reg) * 36'(sd_reg[31:28]);

    // decision terms
    assign xsq_ext = {16'd0, xsq_reg, 16'd0};
    assign is_bad  = (xsq_reg != 32'd0) && (xsq_ext >= pb_reg);
    assign is_warn = (xsq_reg != 32'd0) && (xsq_ext >= pw_reg);
    assign since   = time_reg - last_alert_reg;
    assign elapsed = (time_reg >= last_alert_reg) && (since >= 63'(cooldown_reg));

    always_comb begin
        state_next       = state_reg;
        cnt_next         = cnt_reg;
        m_tvalid_next    = m_tvalid_reg;
        last_alert_next  = last_alert_reg;
        sent_before_next = sent_before_reg;
        was_bad_next     = was_bad_reg;
        warn_ratio_next  = warn_ratio_reg;
        bad_ratio_next   = bad_ratio_reg;
        cooldown_next    = cooldown_reg;
        study_next       = study_reg;
        ok_next          = ok_reg;
        xm_next          = xm_reg;
        ym_next          = ym_reg;
        zm_next          = zm_reg;
        xd_next          = xd_reg;
        yd_next          = yd_reg;
        zd_next          = zd_reg;
        xsq_next         = xsq_reg;
        ysq_next         = ysq_reg;
        zsq_next         = zsq_reg;
        sd_next          = sd_reg;
        pw_next          = pw_reg;
        pb_next          = pb_reg;
        time_next        = time_reg;
        verdict_next     = verdict_reg;
        face_next        = face_reg;
        alert_next       = alert_reg;
        wake_next        = wake_reg;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        if (cfg_we) begin
            unique case (cfg_addr)
                tpa_pkg::REG_WARN_RATIO: warn_ratio_next = cfg_wdata;
                tpa_pkg::REG_BAD_RATIO:  bad_ratio_next  = cfg_wdata;
                tpa_pkg::REG_COOLDOWN:   cooldown_next   = cfg_wdata;
                tpa_pkg::REG_STUDY_MODE: study_next      = cfg_wdata[0];
                default: ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    ok_next   = in_ok;
                    xm_next   = in_x[15] ? (~in_x + 16'd1) : in_x;
                    ym_next   = in_y[15] ? (~in_y + 16'd1) : in_y;
                    zm_next   = in_z[15] ? (~in_z + 16'd1) : in_z;
                    xd_next   = in_x[15] ? (~in_x + 16'd1) : in_x;
                    yd_next   = in_y[15] ? (~in_y + 16'd1) : in_y;
                    zd_next   = in_z[15] ? (~in_z + 16'd1) : in_z;
                    xsq_next  = 32'd0;
                    ysq_next  = 32'd0;
                    zsq_next  = 32'd0;
                    time_next = s_tdata[111:49];
                    cnt_next  = 3'd0;
                    state_next = in_ok ? ST_SQR : ST_DEC;
                end
            end
            ST_SQR: begin
                xsq_next = {xsq_reg[27:0], 4'd0} + 32'(xp);
                ysq_next = {ysq_reg[27:0], 4'd0} + 32'(yp);
                zsq_next = {zsq_reg[27:0], 4'd0} + 32'(zp);
                xd_next  = {xd_reg[11:0], 4'd0};
                yd_next  = {yd_reg[11:0], 4'd0};
                zd_next  = {zd_reg[11:0], 4'd0};
                cnt_next = cnt_reg + 3'd1;
                if (cnt_reg == SQR_LAST) begin
                    state_next = ST_SIDE;
                end
            end
            ST_SIDE: begin
                sd_next    = ysq_reg + zsq_reg;
                pw_next    = 64'd0;
                pb_next    = 64'd0;
                cnt_next   = 3'd0;
                state_next = ST_MUL;
            end
            ST_MUL: begin
                pw_next  = {pw_reg[59:0], 4'd0} + 64'(wp);
                pb_next  = {pb_reg[59:0], 4'd0} + 64'(bp);
                sd_next  = {sd_reg[27:0], 4'd0};
                cnt_next = cnt_reg + 3'd1;
                if (cnt_reg == MUL_LAST) begin
                    state_next = ST_DEC;
                end
            end
            ST_DEC: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                    face_next     = tpa_pkg::FACE_KEEP;
                    alert_next    = 1'b0;
                    if (!ok_reg) begin
                        verdict_next = tpa_pkg::VERDICT_NONE;
                        wake_next    = 1'b1;
                    end else begin
                        wake_next = 1'b0;
                        if (is_bad) begin
                            verdict_next = tpa_pkg::VERDICT_BAD;
                        end else if (is_warn) begin
                            verdict_next = tpa_pkg::VERDICT_SLIGHT;
                        end else begin
                            verdict_next = tpa_pkg::VERDICT_GOOD;
                        end
                        if (is_bad && study_reg) begin
                            face_next    = tpa_pkg::FACE_ANGRY;
                            was_bad_next = 1'b1;
                            if (!sent_before_reg || elapsed) begin
                                last_alert_next  = time_reg;
                                sent_before_next = 1'b1;
                                alert_next       = 1'b1;
                            end
                        end else if (!is_warn && was_bad_reg) begin
                            face_next    = tpa_pkg::FACE_HAPPY;
                            was_bad_next = 1'b0;
                        end
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            cnt_reg         <= 3'd0;
            m_tvalid_reg    <= 1'b0;
            last_alert_reg  <= '0;
            sent_before_reg <= 1'b0;
            was_bad_reg     <= 1'b0;
            warn_ratio_reg  <= tpa_pkg::WARN_RATIO_RST;
            bad_ratio_reg   <= tpa_pkg::BAD_RATIO_RST;
            cooldown_reg    <= tpa_pkg::COOLDOWN_RST;
            study_reg       <= 1'b0;
        end else begin
            state_reg       <= state_next;
            cnt_reg         <= cnt_next;
            m_tvalid_reg    <= m_tvalid_next;
            last_alert_reg  <= last_alert_next;
            sent_before_reg <= sent_before_next;
            was_bad_reg     <= was_bad_next;
            warn_ratio_reg  <= warn_ratio_next;
            bad_ratio_reg   <= bad_ratio_next;
            cooldown_reg    <= cooldown_next;
            study_reg       <= study_next;
        end
    end

    always_ff @(posedge aclk) begin
        ok_reg      <= ok_next;
        xm_reg      <= xm_next;
        ym_reg      <= ym_next;
        zm_reg      <= zm_next;
        xd_reg      <= xd_next;
        yd_reg      <= yd_next;
        zd_reg      <= zd_next;
        xsq_reg     <= xsq_next;
        ysq_reg     <= ysq_next;
        zsq_reg     <= zsq_next;
        sd_reg      <= sd_next;
        pw_reg      <= pw_next;
        pb_reg      <= pb_next;
        time_reg    <= time_next;
        verdict_reg <= verdict_next;
        face_reg    <= face_next;
        alert_reg   <= alert_next;
        wake_reg    <= wake_next;
    end

endmodule

// ===== hdl/tpa_checker.sv =====
// port-level checks on the result words of the tilt posture alarm unit
// depends on tpa_pkg and tilt_posture_alarm_unit_defines.svh; bound to the top level
`include "tilt_posture_alarm_unit_defines.svh"

module tpa_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [tpa_pkg::M_DATA_W-1:0]  m_tdata
);

    tpa_pkg::verdict_t verdict;
    tpa_pkg::face_t    face;
    logic              alert;
    logic              wake;

    assign verdict = m_tdata[1:0];
    assign face    = m_tdata[3:2];
    assign alert   = m_tdata[4];
    assign wake    = m_tdata[5];

    `TPA_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result word changed while stalled")
    `TPA_ASSERT_NOW(a_wake_only_no_reading, aclk, aresetn, m_tvalid, (verdict == tpa_pkg::VERDICT_NONE) == wake, "wake request and no-reading verdict disagree")
    `TPA_ASSERT_NOW(a_alert_with_angry, aclk, aresetn, m_tvalid && alert, (face == tpa_pkg::FACE_ANGRY) && (verdict == tpa_pkg::VERDICT_BAD), "alert without bad verdict and angry face")
    `TPA_ASSERT_NOW(a_angry_is_bad, aclk, aresetn, m_tvalid && (face == tpa_pkg::FACE_ANGRY), verdict == tpa_pkg::VERDICT_BAD, "angry face on a verdict other than bad")
    `TPA_ASSERT_NOW(a_happy_below_warn, aclk, aresetn, m_tvalid && (face == tpa_pkg::FACE_HAPPY), (verdict == tpa_pkg::VERDICT_GOOD) || (verdict == tpa_pkg::VERDICT_BAD), "happy face on slight lean or missing reading")

endmodule

bind tilt_posture_alarm_unit tpa_checker u_tpa_checker (.*);
